@@ hw/rtl/grid_block_allocator_core_assert.svh @@
// Assertion macros for the grid block allocator.
// Used by grid_block_allocator_core; no other dependencies.
`ifndef GRID_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define GRID_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("grid block allocator assertion failed");
`define GBA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("grid block allocator assertion failed");
`else
`define GBA_ASSERT(lbl, clk, rstn, prop)
`define GBA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/gba_pkg.sv @@
// Shared types and codes for the grid block allocator.
// No dependencies.
`default_nettype none

package gba_pkg;

  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic MODE_EVERY   = 1'b0;
  localparam logic MODE_ALIGNED = 1'b1;

  typedef struct packed {
    logic       granted;
    logic [1:0] start_row;
    logic [1:0] start_col;
  } gba_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/grid_block_allocator_core.sv @@
// First-fit allocator of rectangular core blocks on a grid, top level.
// Depends on gba_pkg and grid_block_allocator_core_assert.svh.
`default_nettype none

// The block keeps one busy bit per core in flip-flops and serves one item at a time. A reserve
// item tests one candidate origin per cycle with a single shared block-overlap check, so it
// holds in_stall_o high until its result moves to the output register, trying at most
// GRID_ROWS * GRID_COLS origins; a release item passes through the scan state once, and a zero
// or oversize reserve skips it. The result goes to an output register, so the next item may be
// accepted while it waits; a new result waits in its final state until that register is free.
module grid_block_allocator_core #(
  parameter int GRID_ROWS = 4,
  parameter int GRID_COLS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic       search_mode_i,
  input  wire logic [2:0] block_rows_i,
  input  wire logic [2:0] block_cols_i,
  input  wire logic [1:0] region_row_i,
  input  wire logic [1:0] region_col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            granted_o,
  output logic [1:0]      start_row_o,
  output logic [1:0]      start_col_o
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int RW    = $clog2(GRID_ROWS + 16);
  localparam int CW    = $clog2(GRID_COLS + 16);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 req_q, req_d;
  logic                 mode_q, mode_d;
  logic [2:0]           h_q, h_d;
  logic [2:0]           w_q, w_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic [CELLS-1:0]     busy_q, busy_d;
  gba_pkg::gba_result_t res_q, res_d;
  gba_pkg::gba_result_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [CELLS-1:0] blk_mask;
  logic             blk_free;
  logic             in_acc;
  logic             size_bad;
  logic [RW-1:0]    step_r, row_nx;
  logic [CW-1:0]    step_c, col_nx;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign size_bad = (block_rows_i == 3'd0) || (block_cols_i == 3'd0) ||
                    (RW'(block_rows_i) > RW'(GRID_ROWS)) ||
                    (CW'(block_cols_i) > CW'(GRID_COLS));

  always_comb begin
    for (int i = 0; i < GRID_ROWS; i++) begin
      for (int j = 0; j < GRID_COLS; j++) begin
        blk_mask[i*GRID_COLS+j] = (RW'(i) >= row_q) && (RW'(i) < row_q + RW'(h_q)) &&
                                  (CW'(j) >= col_q) && (CW'(j) < col_q + CW'(w_q));
      end
    end
  end

  assign blk_free = ~|(blk_mask & busy_q);
  assign step_r   = (mode_q == gba_pkg::MODE_ALIGNED) ? RW'(h_q) : RW'(1);
  assign step_c   = (mode_q == gba_pkg::MODE_ALIGNED) ? CW'(w_q) : CW'(1);
  assign row_nx   = row_q + step_r;
  assign col_nx   = col_q + step_c;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    mode_d      = mode_q;
    h_d         = h_q;
    w_d         = w_q;
    row_d       = row_q;
    col_d       = col_q;
    busy_d      = busy_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d = req_type_i;
          mode_d = search_mode_i;
          h_d = block_rows_i;
          w_d = block_cols_i;
          res_d = '0;
          if (req_type_i == gba_pkg::REQ_RELEASE) begin
            row_d = RW'(region_row_i);
            col_d = CW'(region_col_i);
            state_d = ST_SCAN;
          end else if (size_bad) begin
            state_d = ST_DONE;
          end else begin
            row_d = '0;
            col_d = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (req_q == gba_pkg::REQ_RELEASE) begin
          busy_d = busy_q & ~blk_mask;
          res_d.granted = 1'b1;
          state_d = ST_DONE;
        end else if (blk_free) begin
          busy_d = busy_q | blk_mask;
          res_d.granted = 1'b1;
          res_d.start_row = row_q[1:0];
          res_d.start_col = col_q[1:0];
          state_d = ST_DONE;
        end else if (col_nx + CW'(w_q) <= CW'(GRID_COLS)) begin
          col_d = col_nx;
        end else if (row_nx + RW'(h_q) <= RW'(GRID_ROWS)) begin
          row_d = row_nx;
          col_d = '0;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    mode_q <= mode_d;
    h_q    <= h_d;
    w_q    <= w_d;
    row_q  <= row_d;
    col_q  <= col_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = out_q.granted;
  assign start_row_o = out_q.start_row;
  assign start_col_o = out_q.start_col;

`include "grid_block_allocator_core_assert.svh"

  `GBA_ASSERT(a_map_only_in_scan, clk_i, rst_ni, (state_q != ST_SCAN) |=> $stable(busy_q))
  `GBA_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_acc |=> (state_q != ST_IDLE))
  `GBA_ASSERT(a_fail_zero_coords, clk_i, rst_ni, (out_valid_o && !granted_o) |-> (out_q == '0))
  `GBA_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
  `GBA_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> (state_q == ST_IDLE && !out_valid_o))

endmodule

`default_nettype wire
